FILE: hw/rtl/lz4bsp_pkg.sv
// Package for the LZ4 block sequence parser.
// Holds the parse phase and result kind codes, the result struct and the format constants.
// No dependencies.
package lz4bsp_pkg;

  localparam int unsigned LENGTH_BITS = 24;
  localparam int unsigned MATCH_LEN_W = 24;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned MATCH_MIN   = 4;

  localparam logic [3:0] NIBBLE_ESC = 4'hf;
  localparam logic [7:0] BYTE_ESC   = 8'hff;

  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_EXT   = 3'd1,
    PH_LITERALS  = 3'd2,
    PH_OFF_LO    = 3'd3,
    PH_OFF_HI    = 3'd4,
    PH_MATCH_EXT = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_END     = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             literal_value;
    logic [OFFSET_W-1:0]    match_offset;
    logic [MATCH_LEN_W-1:0] match_length;
    logic                   last_of_block;
  } res_t;

endpackage

FILE: hw/rtl/lz4bsp_if.sv
// Stream interfaces of the LZ4 block sequence parser: compressed bytes in, parse results out.
// Depends on lz4bsp_pkg.
interface lz4bsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

interface lz4bsp_result_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [7:0]                          literal_value;
  logic [lz4bsp_pkg::OFFSET_W-1:0]    match_offset;
  logic [lz4bsp_pkg::MATCH_LEN_W-1:0] match_length;
  logic                                last_of_block;

  modport source (output valid, output kind, output literal_value, output match_offset,
                  output match_length, output last_of_block, input ready);
  modport sink   (input valid, input kind, input literal_value, input match_offset,
                  input match_length, input last_of_block, output ready);
endinterface

FILE: hw/rtl/lz4_block_sequence_parser.sv
// Top level of the LZ4 block sequence parser: handshakes, result register, assertions.
// Depends on lz4bsp_pkg, lz4bsp_if.sv and lz4bsp_seq_fsm.
//
//   port       dir  transfer carries
//   byte_i     in   data_byte, block_last
//   result_o   out  kind, literal_value, match_offset, match_length, last_of_block
//
// One byte per cycle while byte_i.ready is high; a result appears in the result register the cycle after its byte.
// Throughput is set by the single state update of the sequence FSM per byte.
// byte_i.ready is high while the result register is empty or being drained this cycle.
// Reset (rst_ni low, async) returns to the token phase with an empty result register.
module lz4_block_sequence_parser #(
  parameter int unsigned LengthBits = lz4bsp_pkg::LENGTH_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lz4bsp_byte_if.sink            byte_i,
  lz4bsp_result_if.source        result_o
);

  logic             accept;
  logic             emit;
  lz4bsp_pkg::res_t fsm_res;
  logic             out_valid_q, out_valid_d;
  lz4bsp_pkg::res_t res_q;

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;

  lz4bsp_seq_fsm #(
    .LengthBits (LengthBits)
  ) u_seq_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (byte_i.data_byte),
    .block_last_i (byte_i.block_last),
    .emit_o       (emit),
    .result_o     (fsm_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= fsm_res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.kind          = res_q.kind;
  assign result_o.literal_value = res_q.literal_value;
  assign result_o.match_offset  = res_q.match_offset;
  assign result_o.match_length  = res_q.match_length;
  assign result_o.last_of_block = res_q.last_of_block;

  // every block's final byte produces exactly one result
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && byte_i.block_last |-> emit)
    else $error("final byte of block produced no result");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |-> fsm_res.last_of_block == byte_i.block_last)
    else $error("last_of_block does not follow block_last");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |=> out_valid_q)
    else $error("result of accepted byte not registered");

endmodule

FILE: hw/rtl/lz4bsp_seq_fsm.sv
// Sequence state machine of the LZ4 block parser: phase, lengths and offset bytes.
// Produces at most one result per accepted byte. Depends on lz4bsp_pkg.
module lz4bsp_seq_fsm #(
  parameter int unsigned LengthBits = lz4bsp_pkg::LENGTH_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             block_last_i,
  output logic             emit_o,
  output lz4bsp_pkg::res_t result_o
);

  localparam int unsigned WideBits = (LengthBits > lz4bsp_pkg::MATCH_LEN_W) ?
                                     LengthBits : lz4bsp_pkg::MATCH_LEN_W;
  localparam logic [LengthBits-1:0] LenMax = '1;

  lz4bsp_pkg::phase_e    phase_q, phase_d;
  logic [3:0]            match_nibble_q, match_nibble_d;
  logic [LengthBits-1:0] literals_left_q, literals_left_d;
  logic [LengthBits-1:0] length_accum_q, length_accum_d;
  logic [7:0]            offset_low_q, offset_low_d;
  logic [7:0]            offset_high_q, offset_high_d;

  logic [LengthBits:0]   accum_sum;
  logic [LengthBits-1:0] accum_sat;
  logic [LengthBits-1:0] lit_dec;
  logic [LengthBits-1:0] match_len;
  logic [WideBits-1:0]   match_len_ext;
  logic [3:0]            lit_nibble;
  logic                  done;

  // saturating add shared by both extension phases
  assign accum_sum = {1'b0, length_accum_q} + (LengthBits + 1)'(data_byte_i);
  assign accum_sat = accum_sum[LengthBits] ? LenMax : accum_sum[LengthBits-1:0];
  assign lit_dec   = literals_left_q - LengthBits'(1);
  assign lit_nibble = data_byte_i[7:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= lz4bsp_pkg::PH_TOKEN;
      match_nibble_q  <= '0;
      literals_left_q <= '0;
      length_accum_q  <= '0;
      offset_low_q    <= '0;
      offset_high_q   <= '0;
    end else if (accept_i) begin
      phase_q         <= phase_d;
      match_nibble_q  <= match_nibble_d;
      literals_left_q <= literals_left_d;
      length_accum_q  <= length_accum_d;
      offset_low_q    <= offset_low_d;
      offset_high_q   <= offset_high_d;
    end
  end

  always_comb begin
    phase_d         = phase_q;
    match_nibble_d  = match_nibble_q;
    literals_left_d = literals_left_q;
    length_accum_d  = length_accum_q;
    offset_low_d    = offset_low_q;
    offset_high_d   = offset_high_q;
    emit_o          = 1'b0;
    done            = 1'b0;
    match_len       = '0;
    result_o        = '0;

    case (phase_q)
      lz4bsp_pkg::PH_LIT_EXT: begin
        length_accum_d = accum_sat;
        if (data_byte_i != lz4bsp_pkg::BYTE_ESC) begin
          literals_left_d = accum_sat;
          phase_d = (accum_sat != '0) ? lz4bsp_pkg::PH_LITERALS : lz4bsp_pkg::PH_OFF_LO;
          length_accum_d = '0;
        end
      end
      lz4bsp_pkg::PH_LITERALS: begin
        literals_left_d = lit_dec;
        if (lit_dec == '0) begin
          phase_d = lz4bsp_pkg::PH_OFF_LO;
          done    = 1'b1;
        end
        // a final byte that leaves literals owed is reported as truncation instead
        if (!block_last_i || done) begin
          emit_o                 = 1'b1;
          result_o.kind          = lz4bsp_pkg::KIND_LITERAL;
          result_o.literal_value = data_byte_i;
          result_o.last_of_block = block_last_i;
        end
      end
      lz4bsp_pkg::PH_OFF_LO: begin
        offset_low_d = data_byte_i;
        phase_d      = lz4bsp_pkg::PH_OFF_HI;
      end
      lz4bsp_pkg::PH_OFF_HI: begin
        offset_high_d = data_byte_i;
        if (match_nibble_q == lz4bsp_pkg::NIBBLE_ESC) begin
          length_accum_d = LengthBits'(lz4bsp_pkg::NIBBLE_ESC) +
                           LengthBits'(lz4bsp_pkg::MATCH_MIN);
          phase_d        = lz4bsp_pkg::PH_MATCH_EXT;
        end else begin
          match_len              = LengthBits'(match_nibble_q) +
                                   LengthBits'(lz4bsp_pkg::MATCH_MIN);
          emit_o                 = 1'b1;
          done                   = 1'b1;
          result_o.kind          = lz4bsp_pkg::KIND_MATCH;
          result_o.match_offset  = {data_byte_i, offset_low_q};
          result_o.last_of_block = block_last_i;
          phase_d                = lz4bsp_pkg::PH_TOKEN;
        end
      end
      lz4bsp_pkg::PH_MATCH_EXT: begin
        length_accum_d = accum_sat;
        if (data_byte_i != lz4bsp_pkg::BYTE_ESC) begin
          match_len              = accum_sat;
          emit_o                 = 1'b1;
          done                   = 1'b1;
          result_o.kind          = lz4bsp_pkg::KIND_MATCH;
          result_o.match_offset  = {offset_high_q, offset_low_q};
          result_o.last_of_block = block_last_i;
          length_accum_d         = '0;
          phase_d                = lz4bsp_pkg::PH_TOKEN;
        end
      end
      default: begin
        // token byte; unreachable phase codes land here too
        match_nibble_d = data_byte_i[3:0];
        if (lit_nibble == lz4bsp_pkg::NIBBLE_ESC) begin
          length_accum_d = LengthBits'(lz4bsp_pkg::NIBBLE_ESC);
          phase_d        = lz4bsp_pkg::PH_LIT_EXT;
        end else begin
          literals_left_d = LengthBits'(lit_nibble);
          phase_d = (lit_nibble != '0) ? lz4bsp_pkg::PH_LITERALS : lz4bsp_pkg::PH_OFF_LO;
          if (lit_nibble == '0 && block_last_i) begin
            emit_o                 = 1'b1;
            done                   = 1'b1;
            result_o.kind          = lz4bsp_pkg::KIND_END;
            result_o.last_of_block = 1'b1;
          end
        end
      end
    endcase

    match_len_ext = WideBits'(match_len);
    if (result_o.kind == lz4bsp_pkg::KIND_MATCH) begin
      result_o.match_length = match_len_ext[lz4bsp_pkg::MATCH_LEN_W-1:0];
    end

    if (block_last_i) begin
      if (!done) begin
        emit_o                 = 1'b1;
        result_o               = '0;
        result_o.kind          = lz4bsp_pkg::KIND_TRUNC;
        result_o.last_of_block = 1'b1;
      end
      phase_d         = lz4bsp_pkg::PH_TOKEN;
      match_nibble_d  = '0;
      literals_left_d = '0;
      length_accum_d  = '0;
      offset_low_d    = '0;
      offset_high_d   = '0;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lz4_block_sequence_parser: compressed LZ4 block bytes in,
// literal / match / block-end / truncation results out, checked against a local parser model.
// Depends on lz4bsp_pkg, lz4bsp_if.sv and the parser RTL.
module testbench;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned RANDOM_BYTES = 520;

  typedef logic [lz4bsp_pkg::LENGTH_BITS-1:0] len_t;
  localparam len_t LEN_MAX = '1;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          drain;
  } comp_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lz4bsp_byte_if   byte_ch ();
  lz4bsp_result_if res_ch ();

  lz4_block_sequence_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (res_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  comp_byte_t           comp_bytes[$];
  logic [7:0]           blk_bytes[$];
  lz4bsp_pkg::res_t     decoded_q[$];
  int unsigned bytes_total = 0;
  int unsigned bytes_sent = 0;
  int unsigned blocks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Parser model state
  lz4bsp_pkg::phase_e ph;
  logic [3:0] m_nib;
  len_t       lits_owed;
  len_t       len_acc;
  logic [7:0] off_lo;
  logic [7:0] off_hi;

  function automatic len_t len_add(input len_t a, input len_t b);
    logic [lz4bsp_pkg::LENGTH_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[lz4bsp_pkg::LENGTH_BITS] ? LEN_MAX : s[lz4bsp_pkg::LENGTH_BITS-1:0];
  endfunction

  function automatic void parse_reset();
    ph = lz4bsp_pkg::PH_TOKEN;
    m_nib = '0;
    lits_owed = '0;
    len_acc = '0;
    off_lo = '0;
    off_hi = '0;
  endfunction

  function automatic void set_literals(input len_t n);
    lits_owed = n;
    ph = (n != 0) ? lz4bsp_pkg::PH_LITERALS : lz4bsp_pkg::PH_OFF_LO;
  endfunction

  // Advances the model by one byte; returns 1 when the byte produces a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output lz4bsp_pkg::res_t r);
    bit         got;
    bit         done;
    logic [3:0] lit_nib;
    got = 1'b0;
    done = 1'b0;
    r = '0;
    r.last_of_block = last;
    case (ph)
      lz4bsp_pkg::PH_LIT_EXT: begin
        len_acc = len_add(len_acc, len_t'(b));
        if (b != lz4bsp_pkg::BYTE_ESC) begin
          set_literals(len_acc);
          len_acc = '0;
        end
      end
      lz4bsp_pkg::PH_LITERALS: begin
        lits_owed = lits_owed - 1'b1;
        if (lits_owed == 0) begin
          ph = lz4bsp_pkg::PH_OFF_LO;
          done = 1'b1;
        end
        if (!last || done) begin
          r.kind = lz4bsp_pkg::KIND_LITERAL;
          r.literal_value = b;
          got = 1'b1;
        end
      end
      lz4bsp_pkg::PH_OFF_LO: begin
        off_lo = b;
        ph = lz4bsp_pkg::PH_OFF_HI;
      end
      lz4bsp_pkg::PH_OFF_HI: begin
        off_hi = b;
        if (m_nib == lz4bsp_pkg::NIBBLE_ESC) begin
          len_acc = len_add(len_t'(lz4bsp_pkg::NIBBLE_ESC), len_t'(lz4bsp_pkg::MATCH_MIN));
          ph = lz4bsp_pkg::PH_MATCH_EXT;
        end else begin
          r.kind = lz4bsp_pkg::KIND_MATCH;
          r.match_offset = {off_hi, off_lo};
          r.match_length = len_add(len_t'(m_nib), len_t'(lz4bsp_pkg::MATCH_MIN));
          got = 1'b1;
          done = 1'b1;
          ph = lz4bsp_pkg::PH_TOKEN;
        end
      end
      lz4bsp_pkg::PH_MATCH_EXT: begin
        len_acc = len_add(len_acc, len_t'(b));
        if (b != lz4bsp_pkg::BYTE_ESC) begin
          r.kind = lz4bsp_pkg::KIND_MATCH;
          r.match_offset = {off_hi, off_lo};
          r.match_length = len_acc;
          got = 1'b1;
          done = 1'b1;
          len_acc = '0;
          ph = lz4bsp_pkg::PH_TOKEN;
        end
      end
      default: begin
        lit_nib = b[7:4];
        m_nib = b[3:0];
        if (lit_nib == lz4bsp_pkg::NIBBLE_ESC) begin
          len_acc = len_t'(lz4bsp_pkg::NIBBLE_ESC);
          ph = lz4bsp_pkg::PH_LIT_EXT;
        end else begin
          set_literals(len_t'(lit_nib));
          if (lit_nib == 0 && last) begin
            r.kind = lz4bsp_pkg::KIND_END;
            got = 1'b1;
            done = 1'b1;
          end
        end
      end
    endcase
    if (last) begin
      // block closed with the sequence still open
      if (!done) begin
        r = '0;
        r.kind = lz4bsp_pkg::KIND_TRUNC;
        r.last_of_block = 1'b1;
        got = 1'b1;
      end
      parse_reset();
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  task automatic add_byte(input logic [7:0] b);
    blk_bytes.insert(blk_bytes.size(), b);
  endtask

  task automatic flush_block(input bit quiet, input bit drain);
    comp_byte_t cb;
    foreach (blk_bytes[i]) begin
      cb.data = blk_bytes[i];
      cb.last = (i == blk_bytes.size() - 1);
      cb.gap = quiet ? 0 : $urandom_range(0, 18);
      cb.drain = drain && (i == 0);
      comp_bytes.insert(comp_bytes.size(), cb);
    end
    blk_bytes.delete();
    blocks_sent++;
  endtask

  task automatic put_ext(input int unsigned rem);
    while (rem >= lz4bsp_pkg::BYTE_ESC) begin
      add_byte(lz4bsp_pkg::BYTE_ESC);
      rem -= lz4bsp_pkg::BYTE_ESC;
    end
    add_byte(8'(rem));
  endtask

  task automatic put_sequence(input int unsigned nlit, input bit with_match,
                              input int unsigned mlen, input logic [15:0] off);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = (nlit >= lz4bsp_pkg::NIBBLE_ESC) ? lz4bsp_pkg::NIBBLE_ESC : 4'(nlit);
    if (with_match)
      lo = (mlen - lz4bsp_pkg::MATCH_MIN >= lz4bsp_pkg::NIBBLE_ESC) ?
           lz4bsp_pkg::NIBBLE_ESC : 4'(mlen - lz4bsp_pkg::MATCH_MIN);
    else
      lo = 4'($urandom);
    add_byte({hi, lo});
    if (nlit >= lz4bsp_pkg::NIBBLE_ESC) put_ext(nlit - lz4bsp_pkg::NIBBLE_ESC);
    repeat (nlit) add_byte(8'($urandom));
    if (with_match) begin
      add_byte(off[7:0]);
      add_byte(off[15:8]);
      if (mlen - lz4bsp_pkg::MATCH_MIN >= lz4bsp_pkg::NIBBLE_ESC)
        put_ext(mlen - lz4bsp_pkg::MATCH_MIN - lz4bsp_pkg::NIBBLE_ESC);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver
  int         gap_left = -1;
  comp_byte_t cur;

  always @(posedge clk_i) begin
    lz4bsp_pkg::res_t r;
    logic nxt_valid;
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= '0;
      byte_ch.block_last <= 1'b0;
      parse_reset();
    end else begin
      nxt_valid = byte_ch.valid;
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_sent++;
        if (decode_byte(byte_ch.data_byte, byte_ch.block_last, r))
          decoded_q.insert(decoded_q.size(), r);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && comp_bytes.size() != 0) begin
        if (gap_left < 0) gap_left = comp_bytes[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!comp_bytes[0].drain || decoded_q.size() == 0) begin
          cur = comp_bytes.pop_front();
          byte_ch.data_byte <= cur.data;
          byte_ch.block_last <= cur.last;
          nxt_valid = 1'b1;
          gap_left = -1;
        end
      end
      byte_ch.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    lz4bsp_pkg::res_t got;
    lz4bsp_pkg::res_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind = lz4bsp_pkg::kind_e'(res_ch.kind);
        got.literal_value = res_ch.literal_value;
        got.match_offset = res_ch.match_offset;
        got.match_length = res_ch.match_length;
        got.last_of_block = res_ch.last_of_block;
        if (decoded_q.size() == 0) begin
          $display("%0t: expected none, got kind %0d lit %0h off %0h len %0h last %0b",
                   $time, got.kind, got.literal_value, got.match_offset, got.match_length,
                   got.last_of_block);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          cmp_field("kind", 32'(want.kind), 32'(got.kind));
          cmp_field("literal_value", 32'(want.literal_value), 32'(got.literal_value));
          cmp_field("match_offset", 32'(want.match_offset), 32'(got.match_offset));
          cmp_field("match_length", 32'(want.match_length), 32'(got.match_length));
          cmp_field("last_of_block", 32'(want.last_of_block), 32'(got.last_of_block));
        end
        kind_count[got.kind]++;
        results_seen++;
        // every fourth stretch of 64 results runs without stalls
        stall_left = ((results_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, 18);
        if (!hold_done && results_seen == 100) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      res_ch.ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no transfer on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, decoded_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rand_bytes;
    int unsigned nseq;
    int unsigned sel;
    int unsigned nlit;
    int unsigned mlen;
    int unsigned cut;
    logic [15:0] off;
    bit          quiet;

    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.block_last = 1'b0;
    res_ch.ready = 1'b0;

    // directed: empty final tokens, owed-literal and owed-match-extension truncations,
    // extended match, zero offset, final literal
    blk_bytes = '{8'h00};                               flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h07};                               flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h10};                               flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h21, 8'haa, 8'h55, 8'h34, 8'h12, 8'h00}; flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h0f, 8'hff, 8'hff, 8'hff, 8'h00};   flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h30, 8'h11, 8'h22};                 flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h10, 8'h00};                        flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h00, 8'h00, 8'h00};                 flush_block(1'b0, 1'b0);
    blk_bytes = '{8'h0f, 8'h12, 8'h34};                 flush_block(1'b0, 1'b0);
    blk_bytes = '{8'hf0, 8'h03};                        flush_block(1'b0, 1'b1);

    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      sel = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      if (sel == 0) begin
        // noise
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      end else begin
        nseq = $urandom_range(1, 4);
        for (int s = 0; s < nseq; s++) begin
          sel = $urandom_range(0, 99);
          if (sel < 50) nlit = $urandom_range(0, 4);
          else if (sel < 75) nlit = $urandom_range(5, 14);
          else if (sel < 98) nlit = $urandom_range(15, 20);
          else nlit = $urandom_range(270, 272);
          sel = $urandom_range(0, 9);
          if (sel < 6) mlen = $urandom_range(4, 18);
          else if (sel < 9) mlen = $urandom_range(19, 40);
          else mlen = $urandom_range(274, 280);
          off = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
          put_sequence(nlit, (s != nseq - 1) || $urandom_range(0, 1), mlen, off);
        end
        // truncated block
        if ($urandom_range(0, 6) == 0 && blk_bytes.size() > 1) begin
          cut = $urandom_range(1, blk_bytes.size() - 1);
          while (blk_bytes.size() > cut) void'(blk_bytes.pop_back());
        end
      end
      rand_bytes += blk_bytes.size();
      flush_block(quiet, (blocks_sent % 15) == 0);
    end
    bytes_total = comp_bytes.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_sent != bytes_total || decoded_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Parsed %0d bytes in %0d blocks with back-pressure and drains, %0d results:",
             bytes_sent, blocks_sent, results_seen);
    $display("  %0d literals, %0d matches, %0d block ends, %0d truncated blocks",
             kind_count[lz4bsp_pkg::KIND_LITERAL], kind_count[lz4bsp_pkg::KIND_MATCH],
             kind_count[lz4bsp_pkg::KIND_END], kind_count[lz4bsp_pkg::KIND_TRUNC]);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: lz4_block_sequence_parser.f
hw/rtl/lz4bsp_pkg.sv
hw/rtl/lz4bsp_if.sv
hw/rtl/lz4bsp_seq_fsm.sv
hw/rtl/lz4_block_sequence_parser.sv
tb/testbench.sv
